>>> sv/qts_pkg.sv
// ----------------------------------------------------------------------------
// qts_pkg: shared definitions for the query template substituter
// Operation codes, special characters and default sizes.
// ----------------------------------------------------------------------------
package qts_pkg;

  localparam int unsigned EntriesDef  = 10;
  localparam int unsigned StrBytesDef = 20;

  localparam logic [7:0] CharAmp          = 8'h26;
  localparam logic [7:0] CharEq           = 8'h3D;
  localparam logic [7:0] SentinelResetVal = 8'h23;

  typedef enum logic [1:0] {
    OP_BEGIN    = 2'd0,
    OP_QUERY    = 2'd1,
    OP_TEMPLATE = 2'd2,
    OP_UNUSED   = 2'd3
  } op_e;

endpackage

>>> sv/qts_ram.sv
// ----------------------------------------------------------------------------
// qts_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module qts_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

>>> sv/query_template_substituter.sv
// ----------------------------------------------------------------------------
// query_template_substituter: query string table and template expansion
// Collects name/value pairs from a query and expands variables in a template.
// ----------------------------------------------------------------------------
// Usage: the slave stream carries one item per transfer: tuser holds the
// operation (begin, query byte, template byte) and tdata the byte. The master
// stream carries the expanded template bytes, tlast marking the last byte
// caused by one input item. cfg_we_i writes the sentinel byte.
// Timing: the block works on one item at a time. Begin, query bytes and
// template bytes that emit at most one byte are taken in idle, as long as
// the output register is free. A closing sentinel walks the entry table,
// comparing each name of the pending name's length byte by byte (names and
// the pending name live in single-port-read RAMs), then reads each emitted
// value byte through the value RAM.
// Reset clears the table lengths, the escape state and the sentinel (to '#');
// the string RAMs need no clearing since they are read only within lengths.
// A stalled receiver holds the output register, and the block stops taking
// items or emitting value bytes until the transfer completes.
// ----------------------------------------------------------------------------
module query_template_substituter #(
  parameter int unsigned ENTRIES   = qts_pkg::EntriesDef,
  parameter int unsigned STR_BYTES = qts_pkg::StrBytesDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,       // sentinel_char
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,    // [7:0] in_byte
  input  logic [1:0] s_axis_tuser_i,    // [1:0] op
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,    // [7:0] out_byte
  output logic       m_axis_tlast_o
);

  import qts_pkg::*;

  localparam int unsigned CAP  = STR_BYTES - 1;
  localparam int unsigned LW   = $clog2(STR_BYTES);
  localparam int unsigned EW   = $clog2(ENTRIES + 1);
  localparam int unsigned IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned AW   = $clog2(ENTRIES * CAP + 1);
  localparam int unsigned PAW  = (CAP > 1) ? $clog2(CAP) : 1;
  localparam logic [LW-1:0] CapL     = LW'(CAP);
  localparam logic [AW-1:0] CapA     = AW'(CAP);
  localparam logic [EW-1:0] EntriesL = EW'(ENTRIES);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_CMP, ST_CHK, ST_EMIT_RD, ST_EMIT_WAIT
  } state_e;

  state_e         state_q;
  logic [7:0]     sentinel_q;
  logic [LW-1:0]  name_len_q [ENTRIES];
  logic [LW-1:0]  val_len_q  [ENTRIES];
  logic [EW-1:0]  qidx_q;
  logic [AW-1:0]  qbase_q;
  logic           wval_q;
  logic [LW-1:0]  plen_q;
  logic           esc_q;
  logic [EW-1:0]  sidx_q;
  logic [AW-1:0]  sbase_q;
  logic [LW-1:0]  cj_q;
  logic           out_valid_q;
  logic [7:0]     out_byte_q;
  logic           out_last_q;

  logic           out_free;
  logic           out_load;
  logic           accept;
  op_e            op;
  logic [7:0]     in_b;
  logic [IW-1:0]  len_idx;
  logic [LW-1:0]  cur_nlen, cur_vlen;
  logic           q_active;
  logic           name_we, val_we, pend_we;
  logic [AW-1:0]  qwaddr;
  logic [7:0]     name_rd, val_rd, pend_rd;

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE) && out_free;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign op              = op_e'(s_axis_tuser_i);
  assign in_b            = s_axis_tdata_i;

  // The output register is loaded by a plain byte, by a doubled sentinel,
  // or by each value byte of a matched name.
  assign out_load = (accept && (op == OP_TEMPLATE)
                     && (((in_b == sentinel_q) && esc_q && (plen_q == '0))
                         || ((in_b != sentinel_q) && !esc_q)))
                    || ((state_q == ST_EMIT_WAIT) && out_free);

  // One length read port: query index while idle, scan index otherwise.
  assign len_idx  = (state_q == ST_IDLE) ? qidx_q[IW-1:0] : sidx_q[IW-1:0];
  assign cur_nlen = name_len_q[len_idx];
  assign cur_vlen = val_len_q[len_idx];

  assign q_active = accept && (op == OP_QUERY) && (qidx_q < EntriesL)
                    && (in_b != CharAmp) && (in_b != CharEq);
  assign name_we  = q_active && !wval_q && (cur_nlen < CapL);
  assign val_we   = q_active && wval_q && (cur_vlen < CapL);
  assign qwaddr   = qbase_q + AW'(wval_q ? cur_vlen : cur_nlen);
  assign pend_we  = accept && (op == OP_TEMPLATE) && (in_b != sentinel_q)
                    && esc_q && (plen_q < CapL);

  qts_ram #(.WIDTH(8), .DEPTH(ENTRIES * CAP), .AW(AW)) u_name_ram (
    .clk_i   (clk_i),
    .we_i    (name_we),
    .waddr_i (qwaddr),
    .wdata_i (in_b),
    .raddr_i (sbase_q + AW'(cj_q)),
    .rdata_o (name_rd)
  );

  qts_ram #(.WIDTH(8), .DEPTH(ENTRIES * CAP), .AW(AW)) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (qwaddr),
    .wdata_i (in_b),
    .raddr_i (sbase_q + AW'(cj_q)),
    .rdata_o (val_rd)
  );

  qts_ram #(.WIDTH(8), .DEPTH(CAP), .AW(PAW)) u_pend_ram (
    .clk_i   (clk_i),
    .we_i    (pend_we),
    .waddr_i (plen_q[PAW-1:0]),
    .wdata_i (in_b),
    .raddr_i (cj_q[PAW-1:0]),
    .rdata_o (pend_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sentinel_q  <= SentinelResetVal;
      for (int i = 0; i < ENTRIES; i++) begin
        name_len_q[i] <= '0;
        val_len_q[i]  <= '0;
      end
      qidx_q      <= '0;
      qbase_q     <= '0;
      wval_q      <= 1'b0;
      plen_q      <= '0;
      esc_q       <= 1'b0;
      sidx_q      <= '0;
      sbase_q     <= '0;
      cj_q        <= '0;
      out_valid_q <= 1'b0;
      out_byte_q  <= '0;
      out_last_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        sentinel_q <= cfg_wdata_i;
      end
      out_valid_q <= out_load || (out_valid_q && !m_axis_tready_i);
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            case (op)
              OP_BEGIN: begin
                for (int i = 0; i < ENTRIES; i++) begin
                  name_len_q[i] <= '0;
                  val_len_q[i]  <= '0;
                end
                qidx_q  <= '0;
                qbase_q <= '0;
                wval_q  <= 1'b0;
                plen_q  <= '0;
                esc_q   <= 1'b0;
              end
              OP_QUERY: begin
                if (qidx_q < EntriesL) begin
                  if (in_b == CharAmp) begin
                    qidx_q  <= qidx_q + 1'b1;
                    qbase_q <= qbase_q + CapA;
                    wval_q  <= 1'b0;
                  end else if (in_b == CharEq) begin
                    wval_q            <= 1'b1;
                    val_len_q[len_idx] <= '0;
                  end else if (val_we) begin
                    val_len_q[len_idx] <= cur_vlen + 1'b1;
                  end else if (name_we) begin
                    name_len_q[len_idx] <= cur_nlen + 1'b1;
                  end
                end
              end
              OP_TEMPLATE: begin
                if (in_b == sentinel_q) begin
                  if (!esc_q) begin
                    esc_q <= 1'b1;
                  end else begin
                    esc_q <= 1'b0;
                    if (plen_q == '0) begin
                      out_byte_q  <= sentinel_q;
                      out_last_q  <= 1'b1;
                    end else begin
                      sidx_q  <= '0;
                      sbase_q <= '0;
                      state_q <= ST_SCAN;
                    end
                  end
                end else if (esc_q) begin
                  if (plen_q < CapL) begin
                    plen_q <= plen_q + 1'b1;
                  end
                end else begin
                  out_byte_q  <= in_b;
                  out_last_q  <= 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          cj_q <= '0;
          if (sidx_q == EntriesL) begin
            plen_q  <= '0;
            state_q <= ST_IDLE;
          end else if (cur_nlen == plen_q) begin
            state_q <= ST_CMP;
          end else begin
            sidx_q  <= sidx_q + 1'b1;
            sbase_q <= sbase_q + CapA;
          end
        end
        ST_CMP: begin
          state_q <= ST_CHK;
        end
        ST_CHK: begin
          if (name_rd != pend_rd) begin
            sidx_q  <= sidx_q + 1'b1;
            sbase_q <= sbase_q + CapA;
            state_q <= ST_SCAN;
          end else if (cj_q == plen_q - 1'b1) begin
            // Match: the value of this entry replaces the name.
            plen_q  <= '0;
            cj_q    <= '0;
            state_q <= (cur_vlen == '0) ? ST_IDLE : ST_EMIT_RD;
          end else begin
            cj_q    <= cj_q + 1'b1;
            state_q <= ST_CMP;
          end
        end
        ST_EMIT_RD: begin
          state_q <= ST_EMIT_WAIT;
        end
        ST_EMIT_WAIT: begin
          if (out_free) begin
            out_byte_q  <= val_rd;
            out_last_q  <= (cj_q == cur_vlen - 1'b1);
            if (cj_q == cur_vlen - 1'b1) begin
              state_q <= ST_IDLE;
            end else begin
              cj_q    <= cj_q + 1'b1;
              state_q <= ST_EMIT_RD;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_byte_q;
  assign m_axis_tlast_o  = out_last_q;

`ifndef NO_ASSERTIONS
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> (state_q == ST_IDLE))
    else $error("input accepted outside idle");

  a_plen_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    plen_q <= CapL)
    else $error("pending name length beyond capacity");

  a_qidx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qidx_q <= EntriesL)
    else $error("entry index beyond table");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready_i) |=> ($stable(out_byte_q) && out_valid_q))
    else $error("stalled output byte overwritten");

  a_scan_no_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && sidx_q == EntriesL) |=> (state_q == ST_IDLE))
    else $error("scan ran past last entry");
`endif

endmodule

>>> tb/sv/tb_query_template_substituter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_query_template_substituter: self-checking bench for the substituter
// Drives query and template bytes over the input stream and compares every
// expanded output byte and its tlast flag against a local table model.
// ----------------------------------------------------------------------------
module tb_query_template_substituter;
  import qts_pkg::*;

  localparam int unsigned NEnt = EntriesDef;
  localparam int unsigned Cap  = StrBytesDef - 1;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_beat_t;

  typedef struct {
    op_e        op;
    logic [7:0] ch;
    int         n_exp;   // -1: use the model; otherwise a typed-in output
    logic [7:0] exp_ch;
  } vec_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [7:0] cfg_wdata_i = '0;
  logic       s_axis_tvalid_i = 1'b0;
  logic       s_axis_tready_o;
  logic [7:0] s_axis_tdata_i = '0;
  logic [1:0] s_axis_tuser_i = '0;
  logic       m_axis_tvalid_o;
  logic       m_axis_tready_i = 1'b0;
  logic [7:0] m_axis_tdata_o;
  logic       m_axis_tlast_o;

  query_template_substituter dut (.*);

  // Local copy of the table and escape state.
  logic [7:0] sentinel;
  logic [7:0] names  [NEnt][Cap];
  logic [7:0] vals   [NEnt][Cap];
  int         name_len [NEnt];
  int         val_len  [NEnt];
  int         cur_entry;
  bit         in_value;
  logic [7:0] pend [Cap];
  int         pend_len;
  bit         escaping;

  out_beat_t  expected_bytes[$];
  int         errors = 0;
  bit         rx_hold = 1'b0;
  bit         rx_quiet = 1'b0;
  bit         tx_quiet = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic report(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic void clear_table();
    for (int i = 0; i < NEnt; i++) begin
      name_len[i] = 0;
      val_len[i]  = 0;
    end
    cur_entry = 0;
    in_value  = 0;
    pend_len  = 0;
    escaping  = 0;
  endfunction

  // Updates the model for one item and queues the bytes it expands to.
  function automatic int expand_item(input op_e op, input logic [7:0] b);
    int n;
    int k;
    bit hit;
    n = 0;
    case (op)
      OP_BEGIN: clear_table();
      OP_QUERY: begin
        if (cur_entry < NEnt) begin
          if (b == CharAmp) begin
            cur_entry++;
            in_value = 0;
          end else if (b == CharEq) begin
            in_value = 1;
            val_len[cur_entry] = 0;
          end else if (in_value) begin
            if (val_len[cur_entry] < Cap) vals[cur_entry][val_len[cur_entry]++] = b;
          end else begin
            if (name_len[cur_entry] < Cap) names[cur_entry][name_len[cur_entry]++] = b;
          end
        end
      end
      OP_TEMPLATE: begin
        if (b == sentinel) begin
          if (!escaping) begin
            escaping = 1;
          end else begin
            if (pend_len == 0) begin
              expected_bytes.push_back('{sentinel, 1'b0});
              n = 1;
            end else begin
              k = -1;
              for (int i = 0; i < NEnt && k < 0; i++) begin
                hit = (name_len[i] == pend_len);
                for (int j = 0; j < pend_len && hit; j++) hit = (names[i][j] == pend[j]);
                if (hit) k = i;
              end
              if (k >= 0) begin
                for (int j = 0; j < val_len[k]; j++)
                  expected_bytes.push_back('{vals[k][j], 1'b0});
                n = val_len[k];
              end
              pend_len = 0;
            end
            escaping = 0;
          end
        end else if (escaping) begin
          if (pend_len < Cap) pend[pend_len++] = b;
        end else begin
          expected_bytes.push_back('{b, 1'b0});
          n = 1;
        end
      end
      default: ;
    endcase
    if (n > 0) expected_bytes[$].last = 1'b1;
    return n;
  endfunction

  // Output checker.
  always @(posedge clk_i) begin
    out_beat_t e;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_bytes.size() == 0) begin
        report($sformatf("unexpected byte %02h", m_axis_tdata_o));
      end else begin
        e = expected_bytes.pop_front();
        if (m_axis_tdata_o !== e.data)
          report($sformatf("byte %02h, expected %02h", m_axis_tdata_o, e.data));
        if (m_axis_tlast_o !== e.last)
          report($sformatf("tlast %b, expected %b", m_axis_tlast_o, e.last));
      end
    end
  end

  // Receiver: random stalls, a quiet stretch, and a long hold-off on request.
  initial begin
    forever begin
      @(posedge clk_i);
      if (rx_hold) begin
        m_axis_tready_i <= 1'b0;
        repeat (300) @(posedge clk_i);
        rx_hold = 1'b0;
      end
      m_axis_tready_i <= rx_quiet || ($urandom_range(99) >= 14);
    end
  end

  task automatic send(input op_e op, input logic [7:0] b, input int n_exp,
                      input logic [7:0] exp_ch);
    int n;
    while (!tx_quiet && $urandom_range(99) < 14) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= op;
    s_axis_tdata_i  <= b;
    do @(posedge clk_i); while (!s_axis_tready_o);
    n = expand_item(op, b);
    if (n_exp >= 0) begin
      if (n != n_exp || (n == 1 && expected_bytes[$].data != exp_ch))
        report($sformatf("directed row op %0d byte %02h disagrees with model", op, b));
    end
  endtask

  task automatic idle_and_drain();
    s_axis_tvalid_i <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk_i);
    // A closing sentinel without a match may still be scanning the table.
    repeat (NEnt * (1 + 2 * Cap) + 2 * Cap + 20) @(posedge clk_i);
  endtask

  task automatic write_sentinel(input logic [7:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sentinel = v;
  endtask

  task automatic send_query(input string s);
    for (int i = 0; i < s.len(); i++) send(OP_QUERY, s[i], -1, 8'h00);
  endtask

  // Mostly well-formed template traffic with variable names drawn from the same letters as the table names.
  task automatic random_phase(input int items);
    int cnt;
    int r;
    int len;
    logic [7:0] c;
    cnt = 0;
    send(OP_BEGIN, 8'($urandom), -1, 8'h00);
    for (int e = 0; e < $urandom_range(12, 3); e++) begin
      if (e != 0) begin
        send(OP_QUERY, CharAmp, -1, 8'h00);
        cnt++;
      end
      len = ($urandom_range(15) == 0) ? $urandom_range(24, 18) : $urandom_range(3, 0);
      for (int j = 0; j < len; j++) send(OP_QUERY, 8'($urandom_range(3) + 8'h61), -1, 8'h00);
      cnt += len;
      if ($urandom_range(4) != 0) begin
        send(OP_QUERY, CharEq, -1, 8'h00);
        len = ($urandom_range(10) == 0) ? $urandom_range(22, 17) : $urandom_range(4);
        for (int j = 0; j < len; j++) send(OP_QUERY, 8'($urandom), -1, 8'h00);
        cnt += len + 1;
      end
    end
    while (cnt < items) begin
      r = $urandom_range(99);
      if (r < 55) begin
        c = 8'($urandom);
        send(OP_TEMPLATE, c, -1, 8'h00);
        cnt++;
      end else if (r < 90) begin
        send(OP_TEMPLATE, sentinel, -1, 8'h00);
        len = ($urandom_range(20) == 0) ? 21 : $urandom_range(3, 0);
        for (int j = 0; j < len; j++) send(OP_TEMPLATE, 8'($urandom_range(3) + 8'h61), -1, 8'h00);
        send(OP_TEMPLATE, sentinel, -1, 8'h00);
        cnt += len + 2;
      end else if (r < 96) begin
        send(OP_QUERY, 8'($urandom), -1, 8'h00);
        cnt++;
      end else begin
        send(($urandom_range(1) == 0) ? OP_UNUSED : OP_BEGIN, 8'($urandom), -1, 8'h00);
        cnt++;
      end
    end
  endtask

  vec_t dir[$];

  initial begin
    sentinel = SentinelResetVal;
    clear_table();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: pass-through extremes, escapes, unused op, then lookups.
    dir = '{
      '{OP_TEMPLATE, 8'h00, 1, 8'h00},
      '{OP_TEMPLATE, 8'hFF, 1, 8'hFF},
      '{OP_TEMPLATE, 8'h23, 0, 8'h00},
      '{OP_TEMPLATE, 8'h23, 1, 8'h23},
      '{OP_UNUSED,   8'h41, 0, 8'h00},
      '{OP_TEMPLATE, 8'h23, 0, 8'h00},
      '{OP_TEMPLATE, 8'h7A, 0, 8'h00},
      '{OP_TEMPLATE, 8'h23, 0, 8'h00},
      '{OP_QUERY,    CharAmp, 0, 8'h00},
      '{OP_QUERY,    8'h00, 0, 8'h00},
      '{OP_QUERY,    CharEq, 0, 8'h00},
      '{OP_QUERY,    8'h55, 0, 8'h00},
      '{OP_QUERY,    CharEq, 0, 8'h00},
      '{OP_QUERY,    8'hAA, 0, 8'h00},
      '{OP_TEMPLATE, 8'h23, 0, 8'h00},
      '{OP_TEMPLATE, 8'h00, 0, 8'h00},
      '{OP_TEMPLATE, 8'h23, 1, 8'hAA},
      '{OP_BEGIN,    8'hFF, 0, 8'h00},
      '{OP_TEMPLATE, 8'h23, 0, 8'h00},
      '{OP_TEMPLATE, 8'h00, 0, 8'h00},
      '{OP_TEMPLATE, 8'h23, 0, 8'h00}
    };
    foreach (dir[i]) send(dir[i].op, dir[i].ch, dir[i].n_exp, dir[i].exp_ch);

    // Long strings and a full table, with a long output hold-off meanwhile.
    send(OP_BEGIN, 8'h00, -1, 8'h00);
    send_query("k=0123456789abcdefghijklmn&&&&&&&&&x=9");
    rx_hold = 1'b1;
    for (int r = 0; r < 4; r++) begin
      send(OP_TEMPLATE, 8'h23, -1, 8'h00);
      send(OP_TEMPLATE, "k", -1, 8'h00);
      send(OP_TEMPLATE, 8'h23, -1, 8'h00);
    end
    idle_and_drain();

    // Random phases through several sentinel settings.
    rx_quiet = 1'b1;
    tx_quiet = 1'b1;
    random_phase(50);
    idle_and_drain();
    rx_quiet = 1'b0;
    tx_quiet = 1'b0;
    write_sentinel(8'h00);
    random_phase(80);
    idle_and_drain();
    write_sentinel(8'hFF);
    random_phase(80);
    idle_and_drain();
    write_sentinel(8'($urandom_range(8'h61, 8'h62)));
    random_phase(50);
    idle_and_drain();
    write_sentinel(SentinelResetVal);
    random_phase(70);
    idle_and_drain();

    if (errors == 0) begin
      $display("** query_template_substituter: PASSED **");
    end else begin
      $display("** query_template_substituter: FAILED **");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("** query_template_substituter: FAILED **");
    $finish;
  end

endmodule
